// ===== rtl/udp_dmx_pkg.sv =====
package udp_dmx_pkg;

    localparam logic [1:0] FN_CLEAR = 2'd0;
    localparam logic [1:0] FN_BIND  = 2'd1;
    localparam logic [1:0] FN_RECV  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_ARG = 3'd1;
    localparam logic [2:0] ST_BOUND   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_SHORT   = 3'd4;
    localparam logic [2:0] ST_BAD_LEN = 3'd5;
    localparam logic [2:0] ST_UNBOUND = 3'd6;

    localparam logic [15:0] HDR_BYTES = 16'd8;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] bind_port;
        logic [7:0]  handler_tag;
        logic [15:0] frame_len;
        logic [15:0] header_src_port;
        logic [15:0] header_dst_port;
        logic [15:0] header_length;
        logic [31:0] source_addr;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  delivered_handler;
        logic [4:0]  slot_index;
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
        logic [15:0] local_port;
        logic [15:0] payload_len;
    } t_rsp;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       scan_start;
        logic       write;
        logic       res_load;
        logic [2:0] res_code;
        logic       res_deliver;
        logic       res_bind;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       bind_bad;
        logic       short_frame;
        logic       bad_len;
        logic       scan_done;
        logic       match;
        logic       free;
        logic       out_busy;
    } t_sts;

endpackage

// ===== rtl/udp_dmx_req_if.sv =====
interface udp_dmx_req_if
    import udp_dmx_pkg::*;
();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/udp_dmx_rsp_if.sv =====
interface udp_dmx_rsp_if
    import udp_dmx_pkg::*;
();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/udp_dmx_ctrl.sv =====
module udp_dmx_ctrl
    import udp_dmx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_WRITE,
        S_REPLY
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_code, n_code;
    logic       r_deliver, n_deliver;
    logic       r_bind, n_bind;

    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_deliver   = r_deliver;
        n_bind      = r_bind;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
                if (i_req_valid) begin
                    n_state   = S_DECIDE;
                    n_deliver = 1'b0;
                    n_bind    = 1'b0;
                end
            end
            S_DECIDE: begin
                n_state = S_REPLY;
                unique case (i_sts.func)
                    FN_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_code      = ST_OK;
                    end
                    FN_BIND: begin
                        if (i_sts.bind_bad) begin
                            n_code = ST_BAD_ARG;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    FN_RECV: begin
                        priority if (i_sts.short_frame) begin
                            n_code = ST_SHORT;
                        end else if (i_sts.bad_len) begin
                            n_code = ST_BAD_LEN;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    default: begin
                        n_code = ST_BAD_ARG;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_REPLY;
                    if (i_sts.func == FN_BIND) begin
                        priority if (i_sts.match) begin
                            n_code = ST_BOUND;
                        end else if (i_sts.free) begin
                            n_code  = ST_OK;
                            n_bind  = 1'b1;
                            n_state = S_WRITE;
                        end else begin
                            n_code = ST_FULL;
                        end
                    end else begin
                        n_code    = i_sts.match ? ST_OK : ST_UNBOUND;
                        n_deliver = i_sts.match;
                    end
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_REPLY;
            end
            S_REPLY: begin
                if (!i_sts.out_busy) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.res_code    = r_code;
        o_cmd.res_deliver = r_deliver;
        o_cmd.res_bind    = r_bind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_code    <= ST_OK;
            r_deliver <= 1'b0;
            r_bind    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_code    <= n_code;
            r_deliver <= n_deliver;
            r_bind    <= n_bind;
        end
    end

endmodule

// ===== rtl/udp_dmx_dp.sv =====
module udp_dmx_dp
    import udp_dmx_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int HANDLER_BITS  = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req_data,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    t_req r_in;

    logic [15:0]             r_port_mem [TABLE_ENTRIES];
    logic [HANDLER_BITS-1:0] r_tag_mem  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_used;

    logic [IDX_W-1:0]        r_rd_idx;
    logic                    r_rd_act;
    logic [IDX_W-1:0]        r_cmp_idx;
    logic                    r_cmp_vld;
    logic                    r_cmp_used;
    logic [15:0]             r_cmp_port;
    logic [HANDLER_BITS-1:0] r_cmp_tag;
    logic                    r_done;

    logic                    r_match;
    logic [IDX_W-1:0]        r_hit_idx;
    logic [HANDLER_BITS-1:0] r_hit_tag;
    logic                    r_free;
    logic [IDX_W-1:0]        r_free_idx;

    logic                    r_out_vld;
    t_rsp                    r_out;

    logic [HANDLER_BITS-1:0] tag_k;
    logic [15:0]             key;
    logic                    hit;
    t_rsp                    res;

    assign tag_k = HANDLER_BITS'(r_in.handler_tag);
    assign key   = (r_in.func == FN_BIND) ? r_in.bind_port : r_in.header_dst_port;
    assign hit   = r_cmp_vld && r_cmp_used && (r_cmp_port == key);

    assign o_sts.func        = r_in.func;
    assign o_sts.bind_bad    = (r_in.bind_port == '0) || (tag_k == '0);
    assign o_sts.short_frame = r_in.frame_len < HDR_BYTES;
    assign o_sts.bad_len     = (r_in.header_length < HDR_BYTES)
                             || (r_in.header_length > r_in.frame_len);
    assign o_sts.scan_done   = r_done;
    assign o_sts.match       = r_match;
    assign o_sts.free        = r_free;
    assign o_sts.out_busy    = r_out_vld && !i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_req_data;
        end
    end

    // slot storage, one read port swept by the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_port_mem[r_free_idx] <= r_in.bind_port;
            r_tag_mem[r_free_idx]  <= tag_k;
        end
        r_cmp_port <= r_port_mem[r_rd_idx];
        r_cmp_tag  <= r_tag_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= r_rd_idx;
        r_cmp_used <= r_used[r_rd_idx];
        if (i_cmd.scan_start) begin
            r_match <= 1'b0;
            r_free  <= 1'b0;
        end else if (r_cmp_vld) begin
            if (hit && !r_match) begin
                r_match   <= 1'b1;
                r_hit_idx <= r_cmp_idx;
                r_hit_tag <= r_cmp_tag;
            end
            if (!r_cmp_used && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_rd_idx  <= '0;
            r_rd_act  <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_used <= '0;
            end else if (i_cmd.write) begin
                r_used[r_free_idx] <= 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_rd_idx  <= '0;
                r_rd_act  <= 1'b1;
                r_cmp_vld <= 1'b0;
                r_done    <= 1'b0;
            end else begin
                r_cmp_vld <= r_rd_act;
                r_done    <= r_cmp_vld && (r_cmp_idx == LAST_IDX);
                if (r_rd_act) begin
                    if (r_rd_idx == LAST_IDX) begin
                        r_rd_act <= 1'b0;
                    end else begin
                        r_rd_idx <= r_rd_idx + IDX_W'(1);
                    end
                end
            end
            if (i_cmd.res_load) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        res        = '0;
        res.status = i_cmd.res_code;
        if (i_cmd.res_bind) begin
            res.slot_index = 5'(r_free_idx);
        end
        if (i_cmd.res_deliver) begin
            res.delivered_handler = 8'(r_hit_tag);
            res.slot_index        = 5'(r_hit_idx);
            res.peer_addr         = r_in.source_addr;
            res.peer_port         = r_in.header_src_port;
            res.local_port        = r_in.header_dst_port;
            res.payload_len       = r_in.header_length - HDR_BYTES;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out <= res;
        end
    end

    assign o_rsp_valid = r_out_vld;
    assign o_rsp_data  = r_out;

endmodule

// ===== rtl/udp_port_demux_table.sv =====
// UDP port binding table. One request beat at a time: clear, bind or receive.
// Clear, unknown operations and requests that fail the argument or length
// checks skip the scan and answer straight after the checks. Bind and receive
// lookups sweep every slot once through the single read port of the slot
// memory; a successful bind then writes the free slot. The response sits in an
// output register; the next request is taken while it waits, and a finished
// item only stalls when the previous response has not been taken yet.
module udp_port_demux_table
    import udp_dmx_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int HANDLER_BITS  = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    udp_dmx_req_if.sink   i_req,
    udp_dmx_rsp_if.source o_rsp
);

    t_cmd cmd;
    t_sts sts;

    udp_dmx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    udp_dmx_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HANDLER_BITS  (HANDLER_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (i_req.data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_data  (o_rsp.data)
    );

endmodule

// ===== rtl/udp_dmx_chk.sv =====
module udp_dmx_chk
    import udp_dmx_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp_data
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response beat dropped while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_data))
        else $error("response beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while previous one still in work");

    a_fail_no_delivery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.status != ST_OK |->
            i_rsp_data.delivered_handler == '0 && i_rsp_data.peer_addr == '0
            && i_rsp_data.payload_len == '0 && i_rsp_data.slot_index == '0)
        else $error("failed request carries delivery fields");

endmodule

bind udp_port_demux_table udp_dmx_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);
